[rtl/core/lmbf_pkg.sv]
package lmbf_pkg;

    localparam int MODULES_ACROSS_DEF = 4;
    localparam int MODULES_DOWN_DEF   = 2;

    localparam logic [1:0] ACT_BEGIN  = 2'd0;
    localparam logic [1:0] ACT_SOURCE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_FLUSH  = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rect_x;
        logic [7:0] rect_y;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic [7:0] pixel_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] module_col;
        logic [2:0] module_row;
        logic [3:0] digit_register;
        logic [7:0] row_bits;
        logic       last;
    } out_item_t;

endpackage

[rtl/core/led_matrix_blit_and_flush.sv]
// A begin item loads the window; a source byte makes two read-modify-write passes.
// Clear zeroes each frame byte in turn (MODULES_ACROSS*MODULES_DOWN*8 bytes).
// Flush reads and compares each frame byte and ends with a closing state; it also stalls
// while a changed byte waits for the output register to be taken on m_ready.
// One item at a time: s_ready stays low until the current item is finished.
// Reset: synchronous active-low aresetn clears the control state, then a clearing pass over
module led_matrix_blit_and_flush #(
    parameter int MODULES_ACROSS = lmbf_pkg::MODULES_ACROSS_DEF,
    parameter int MODULES_DOWN   = lmbf_pkg::MODULES_DOWN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lmbf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lmbf_pkg::out_item_t m_data
);
    // every frame byte (64 by default) zeroes both stores before the first item.

    localparam int PIX_ROWS = MODULES_DOWN * 8;
    localparam int PIX_COLS = MODULES_ACROSS * 8;
    localparam int DEPTH    = PIX_ROWS * MODULES_ACROSS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_RD     = 4'd2;
    localparam logic [3:0] ST_WR     = 4'd3;
    localparam logic [3:0] ST_CLEAR  = 4'd4;
    localparam logic [3:0] ST_FRD    = 4'd5;
    localparam logic [3:0] ST_FCMP   = 4'd6;
    localparam logic [3:0] ST_FOUT   = 4'd7;

    // Frame and shadow memories.
    logic [7:0] frame_mem [DEPTH];
    logic [7:0] shadow_mem [DEPTH];
    logic [7:0] frame_rd_reg, shadow_rd_reg;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    win_x_reg, win_y_reg, win_w_reg, win_h_reg;
    logic [7:0]    src_row_reg;
    logic [4:0]    src_col_reg;
    logic [7:0]    bits_reg;
    logic          half_reg;
    logic          m_valid_reg;
    lmbf_pkg::out_item_t m_data_reg;
    lmbf_pkg::out_item_t pend_reg;
    logic          pend_valid_reg;
    logic [2:0]    f_col_reg, f_dig_reg, f_row_reg;

    // Blit geometry for the current source byte.
    logic [8:0]  py;
    logic [12:0] rel0;
    logic [13:0] px0;
    logic [15:0] sh_bits, sh_mask;
    logic [7:0]  wmask, wbits, mask_b;
    logic        row_ok;
    logic [10:0] byte_col;
    logic [AW-1:0] blit_addr;
    logic        blit_ok;
    logic        col_wrap;
    logic [AW-1:0] addr_inc;
    logic        addr_end;

    // Flush walk handshake terms.
    logic        f_diff;
    logic        out_free;
    logic        f_take;
    logic        f_last;
    logic        walk_step;
    logic        s_accept;

    always_comb begin
        py     = {1'b0, win_y_reg} + {1'b0, src_row_reg};
        row_ok = (src_row_reg < win_h_reg) && (py < 9'(PIX_ROWS));
        rel0   = {src_col_reg, 3'b000};
        px0    = {6'd0, win_x_reg} + {1'b0, rel0};
        for (int b = 0; b < 8; b++) begin
            mask_b[7-b] = ((rel0 + 13'(b)) < {5'd0, win_w_reg})
                          && ((px0 + 14'(b)) < 14'(PIX_COLS));
        end
        sh_bits  = {bits_reg, 8'd0} >> px0[2:0];
        sh_mask  = {mask_b, 8'd0} >> px0[2:0];
        wbits    = half_reg ? sh_bits[7:0] : sh_bits[15:8];
        wmask    = half_reg ? sh_mask[7:0] : sh_mask[15:8];
        byte_col = px0[13:3] + {10'd0, half_reg};
        blit_ok  = row_ok && (byte_col < 11'(MODULES_ACROSS));
        blit_addr = AW'(py * 9'(MODULES_ACROSS) + 9'(byte_col));
        col_wrap = ({1'b0, src_col_reg, 3'b000} + 9'd8) >= {1'b0, win_w_reg};
        addr_inc = addr_reg + AW'(1);
        addr_end = (addr_reg == AW'(DEPTH - 1));
    end

    // A changed byte is held back until the next one is known, so last can be set.
    always_comb begin
        s_accept = (state_reg == ST_IDLE) && s_valid;
        f_diff   = (frame_rd_reg != shadow_rd_reg);
        out_free = !m_valid_reg || m_ready;
        f_take   = (state_reg == ST_FCMP) && f_diff && (!pend_valid_reg || out_free);
        f_last   = (state_reg == ST_FOUT) && pend_valid_reg && out_free;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            ST_INIT:  if (addr_end) state_next = ST_IDLE; else addr_next = addr_inc;
            ST_IDLE: begin
                if (s_valid) begin
                    addr_next = '0;
                    case (s_data.action)
                        lmbf_pkg::ACT_BEGIN:  state_next = ST_IDLE;
                        lmbf_pkg::ACT_SOURCE: state_next = ST_RD;
                        lmbf_pkg::ACT_CLEAR:  state_next = ST_CLEAR;
                        lmbf_pkg::ACT_FLUSH:  state_next = ST_FRD;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD:    state_next = ST_WR;
            ST_WR:    state_next = half_reg ? ST_IDLE : ST_RD;
            ST_CLEAR: if (addr_end) state_next = ST_IDLE; else addr_next = addr_inc;
            ST_FRD:   state_next = ST_FCMP;
            ST_FCMP: begin
                if (f_diff && pend_valid_reg && !out_free) begin
                    state_next = ST_FCMP;
                end else if (addr_end) begin
                    state_next = ST_FOUT;
                end else begin
                    addr_next  = addr_inc;
                    state_next = ST_FRD;
                end
            end
            ST_FOUT: begin
                if (!pend_valid_reg || out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
        walk_step = (state_reg == ST_FCMP) && (state_next == ST_FRD);
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            addr_reg       <= '0;
            win_x_reg      <= '0;
            win_y_reg      <= '0;
            win_w_reg      <= '0;
            win_h_reg      <= '0;
            src_row_reg    <= '0;
            src_col_reg    <= '0;
            bits_reg       <= '0;
            half_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            f_col_reg      <= '0;
            f_dig_reg      <= '0;
            f_row_reg      <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            if ((f_take && pend_valid_reg) || f_last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (f_take) begin
                pend_valid_reg <= 1'b1;
            end else if (f_last) begin
                pend_valid_reg <= 1'b0;
            end
            if (s_accept) begin
                half_reg  <= 1'b0;
                bits_reg  <= s_data.pixel_byte;
                f_col_reg <= '0;
                f_dig_reg <= '0;
                f_row_reg <= '0;
                if (s_data.action == lmbf_pkg::ACT_BEGIN) begin
                    win_x_reg   <= s_data.rect_x;
                    win_y_reg   <= s_data.rect_y;
                    win_w_reg   <= s_data.rect_width;
                    win_h_reg   <= s_data.rect_height;
                    src_row_reg <= '0;
                    src_col_reg <= '0;
                end
            end
            if (state_reg == ST_WR) begin
                half_reg <= 1'b1;
                if (half_reg) begin
                    if (col_wrap) begin
                        src_col_reg <= '0;
                        if (src_row_reg != 8'hFF) src_row_reg <= src_row_reg + 8'd1;
                    end else begin
                        src_col_reg <= src_col_reg + 5'd1;
                    end
                end
            end
            // Walk position: module column, then digit, then module row.
            if (walk_step) begin
                if (f_col_reg == 3'(MODULES_ACROSS - 1)) begin
                    f_col_reg <= '0;
                    if (f_dig_reg == 3'd7) begin
                        f_dig_reg <= '0;
                        f_row_reg <= f_row_reg + 3'd1;
                    end else begin
                        f_dig_reg <= f_dig_reg + 3'd1;
                    end
                end else begin
                    f_col_reg <= f_col_reg + 3'd1;
                end
            end
        end
    end

    // Pending byte: the latest changed byte found by the walk.
    always_ff @(posedge aclk) begin
        if (f_take) begin
            pend_reg.module_col     <= f_col_reg;
            pend_reg.module_row     <= f_row_reg;
            pend_reg.digit_register <= {1'b0, f_dig_reg} + 4'd1;
            pend_reg.row_bits       <= frame_rd_reg;
            pend_reg.last           <= 1'b0;
        end
    end

    // Output register: the pending byte leaves when a newer one turns up,
    // or with last set at the end of the walk.
    always_ff @(posedge aclk) begin
        if (f_take && pend_valid_reg) begin
            m_data_reg <= pend_reg;
        end else if (f_last) begin
            m_data_reg.module_col     <= pend_reg.module_col;
            m_data_reg.module_row     <= pend_reg.module_row;
            m_data_reg.digit_register <= pend_reg.digit_register;
            m_data_reg.row_bits       <= pend_reg.row_bits;
            m_data_reg.last           <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Memory ports.
    logic [AW-1:0] mem_addr;
    assign mem_addr = (state_reg == ST_RD || state_reg == ST_WR) ? blit_addr : addr_reg;

    always_ff @(posedge aclk) begin
        frame_rd_reg  <= frame_mem[mem_addr];
        shadow_rd_reg <= shadow_mem[mem_addr];
        if (state_reg == ST_INIT) begin
            frame_mem[mem_addr]  <= 8'd0;
            shadow_mem[mem_addr] <= 8'd0;
        end
        if (state_reg == ST_CLEAR) frame_mem[mem_addr] <= 8'd0;
        if (state_reg == ST_WR && blit_ok && wmask != 8'd0) begin
            frame_mem[mem_addr] <= (frame_rd_reg & ~wmask) | (wbits & wmask);
        end
        if (f_take) begin
            shadow_mem[mem_addr] <= frame_rd_reg;
        end
    end

endmodule

[tb/led_matrix_blit_and_flush_test.sv]
module led_matrix_blit_and_flush_test;

    localparam int ACROSS = lmbf_pkg::MODULES_ACROSS_DEF;
    localparam int DOWN = lmbf_pkg::MODULES_DOWN_DEF;
    localparam int PIX_ROWS = DOWN * 8;
    localparam int PIX_COLS = ACROSS * 8;
    localparam int DEPTH = PIX_ROWS * ACROSS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lmbf_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lmbf_pkg::out_item_t m_data;

    // Predictor state: frame, shadow, window and source position.
    logic [7:0] frame_bytes [DEPTH];
    logic [7:0] shadow_bytes [DEPTH];
    logic [7:0] win_x, win_y, win_w, win_h, src_row;
    logic [4:0] src_col;

    lmbf_pkg::out_item_t pending_transfers[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit tail_phase = 1'b0;

    always #5 aclk = ~aclk;

    led_matrix_blit_and_flush DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Apply one input transaction to the predictor and queue its transfers.
    task automatic predict_item(input lmbf_pkg::in_item_t it);
        int py, rel, px, idx;
        int first_new;
        begin
            case (it.action)
                lmbf_pkg::ACT_BEGIN: begin
                    win_x = it.rect_x;
                    win_y = it.rect_y;
                    win_w = it.rect_width;
                    win_h = it.rect_height;
                    src_row = '0;
                    src_col = '0;
                end
                lmbf_pkg::ACT_SOURCE: begin
                    py = int'(win_y) + int'(src_row);
                    if (src_row < win_h && py < PIX_ROWS) begin
                        for (int b = 0; b < 8; b++) begin
                            rel = int'(src_col) * 8 + b;
                            px = int'(win_x) + rel;
                            if (rel < win_w && px < PIX_COLS) begin
                                idx = py * ACROSS + px / 8;
                                frame_bytes[idx][7 - px % 8] = it.pixel_byte[7 - b];
                            end
                        end
                    end
                    if ((int'(src_col) + 1) * 8 >= win_w) begin
                        src_col = '0;
                        if (src_row != 8'd255) src_row = src_row + 8'd1;
                    end else begin
                        src_col = src_col + 5'd1;
                    end
                end
                lmbf_pkg::ACT_CLEAR: begin
                    foreach (frame_bytes[i]) frame_bytes[i] = '0;
                end
                default: begin
                    first_new = pending_transfers.size();
                    for (int ym = 0; ym < DOWN; ym++)
                        for (int r = 0; r < 8; r++)
                            for (int xm = 0; xm < ACROSS; xm++) begin
                                idx = (ym * 8 + r) * ACROSS + xm;
                                if (frame_bytes[idx] != shadow_bytes[idx]) begin
                                    shadow_bytes[idx] = frame_bytes[idx];
                                    pending_transfers.push_back(
                                        '{xm[2:0], ym[2:0], 4'(r + 1), frame_bytes[idx], 1'b0});
                                end
                            end
                    if (pending_transfers.size() > first_new)
                        pending_transfers[pending_transfers.size() - 1].last = 1'b1;
                end
            endcase
        end
    endtask

    // Send one transaction, with an optional random gap beforehand.
    task automatic send_item(input lmbf_pkg::in_item_t it);
        begin
            if (!tail_phase && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data <= it;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            predict_item(it);
        end
    endtask

    task automatic send_begin(input int x, input int y, input int w, input int h);
        lmbf_pkg::in_item_t it;
        begin
            it = '0;
            it.action = lmbf_pkg::ACT_BEGIN;
            it.rect_x = x[7:0];
            it.rect_y = y[7:0];
            it.rect_width = w[7:0];
            it.rect_height = h[7:0];
            send_item(it);
        end
    endtask

    task automatic send_op(input logic [1:0] act, input logic [7:0] pix);
        lmbf_pkg::in_item_t it;
        begin
            it = lmbf_pkg::in_item_t'(42'({$urandom, $urandom}));
            it.action = act;
            it.pixel_byte = pix;
            send_item(it);
        end
    endtask

    task automatic wait_drained;
        begin
            s_valid <= 1'b0;
            while (pending_transfers.size() != 0) @(posedge aclk);
        end
    endtask

    // Result side: compare each accepted transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_transfers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer %p", m_data);
                end else begin
                    lmbf_pkg::out_item_t exp_t;
                    exp_t = pending_transfers.pop_front();
                    if (m_data !== exp_t) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_t, m_data);
                    end
                end
            end
        end
    end

    // Random stall bursts on the result side.
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (tail_phase || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                n = $urandom_range(1, 14);
                m_ready <= 1'b0;
                repeat (n - 1) @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Directed checks of extremes and every action.
    task automatic test_directed;
        begin
            send_op(lmbf_pkg::ACT_SOURCE, 8'hFF);
            send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
            send_begin(0, 0, 255, 255);
            repeat (4) send_op(lmbf_pkg::ACT_SOURCE, 8'hA5);
            send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
            send_begin(255, 255, 1, 1);
            send_op(lmbf_pkg::ACT_SOURCE, 8'hFF);
            send_begin(29, 15, 9, 2);
            repeat (4) send_op(lmbf_pkg::ACT_SOURCE, 8'hFF);
            send_begin(3, 2, 0, 3);
            send_op(lmbf_pkg::ACT_SOURCE, 8'h00);
            send_begin(5, 1, 3, 1);
            send_op(lmbf_pkg::ACT_SOURCE, 8'h00);
            send_op(lmbf_pkg::ACT_SOURCE, 8'hFF);
            send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
            send_op(lmbf_pkg::ACT_CLEAR, 8'h00);
            send_op(lmbf_pkg::ACT_SOURCE, 8'h81);
            send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
            send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
        end
    endtask

    // Well-formed blits with random content, plus noise items.
    task automatic test_random_blits(input int items);
        int sent, w, h, nbytes;
        begin
            sent = 0;
            while (sent < items) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(lmbf_pkg::in_item_t'(42'({$urandom, $urandom})));
                    sent++;
                end else begin
                    w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(1, 20);
                    h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(1, 6);
                    send_begin(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 31),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 15),
                               w, h);
                    nbytes = ((w + 7) / 8) * ((h < 6) ? h : 6) + $urandom_range(0, 2);
                    if (nbytes > 12) nbytes = 12;
                    repeat (nbytes) send_op(lmbf_pkg::ACT_SOURCE, 8'($urandom));
                    sent += nbytes + 1;
                    if ($urandom_range(0, 2) == 0) begin
                        send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
                        sent++;
                    end
                    if ($urandom_range(0, 15) == 0) begin
                        send_op(lmbf_pkg::ACT_CLEAR, 8'h00);
                        sent++;
                    end
                end
            end
            send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
        end
    endtask

    // Sender holds off until every queued transfer has arrived.
    task automatic test_hold_off;
        begin
            send_begin(0, 0, 32, 16);
            repeat (8) send_op(lmbf_pkg::ACT_SOURCE, 8'($urandom));
            send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
            wait_drained();
            send_op(lmbf_pkg::ACT_CLEAR, 8'h00);
            send_op(lmbf_pkg::ACT_FLUSH, 8'h00);
        end
    endtask

    initial begin
        foreach (frame_bytes[i]) begin
            frame_bytes[i] = '0;
            shadow_bytes[i] = '0;
        end
        win_x = '0; win_y = '0; win_w = '0; win_h = '0;
        src_row = '0; src_col = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_hold_off();
        test_random_blits(280);
        tail_phase = 1'b1;
        test_random_blits(40);
        wait_drained();
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && pending_transfers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
